/* rtl/register_cache_spill_fill_map_assert.svh */
// Assertion macros shared by the register cache blocks.
`ifndef REGISTER_CACHE_SPILL_FILL_MAP_ASSERT_SVH
`define REGISTER_CACHE_SPILL_FILL_MAP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RCSFM_ASSERT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rcsfm: assertion failed");

// Next-cycle implication, disabled while in reset.
`define RCSFM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rcsfm: assertion failed");

`endif

/* rtl/rcsfm_pkg.sv */
`default_nettype none

package rcsfm_pkg;

  // Table and pool layout
  localparam int NUM_VIRT_DEF = 15;
  localparam int POOL_FIRST   = 4;
  localparam int POOL_END     = 10;

  // Depth of the command queue between front and back
  localparam int Q_DEPTH = 2;

  // Instruction word pieces
  localparam logic [3:0]  COND_AL    = 4'hE;
  localparam logic [31:0] STORE_BASE = 32'h058A_0000;
  localparam logic [31:0] LOAD_BASE  = 32'h059A_0000;

  // Input opcodes
  localparam logic [1:0] OP_MAP_RD = 2'd0;
  localparam logic [1:0] OP_MAP_WR = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_FLUSH = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_ERROR = 3'd4
  } cmd_kind_t;

  // Result kinds
  typedef enum logic [2:0] {
    RES_ANSWER = 3'd0,
    RES_SPILL  = 3'd1,
    RES_FILL   = 3'd2,
    RES_DONE   = 3'd3,
    RES_ERROR  = 3'd4
  } res_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] vr;
  } cmd_t;

  // Store/load word: cond | base | phys<<12 | vreg<<2
  function automatic logic [31:0] make_word(input logic [31:0] base,
                                            input logic [3:0] phys,
                                            input logic [3:0] vreg);
    return {COND_AL, 28'h0} | base | {16'h0, phys, 12'h0} | {26'h0, vreg, 2'b00};
  endfunction

endpackage

`default_nettype wire

/* rtl/rcsfm_if.sv */
`default_nettype none

// Request channel
interface rcsfm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] virt_reg;

  modport source (output valid, output opcode, output virt_reg, input ready);
  modport sink   (input valid, input opcode, input virt_reg, output ready);
endinterface

// Result channel
interface rcsfm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  phys_reg;
  logic [3:0]  vreg_out;
  logic [31:0] code_word;
  logic        last;

  modport source (output valid, output kind, output phys_reg, output vreg_out,
                  output code_word, output last, input ready);
  modport sink   (input valid, input kind, input phys_reg, input vreg_out,
                  input code_word, input last, output ready);
endinterface

`default_nettype wire

/* rtl/rcsfm_front.sv */
`default_nettype none

module rcsfm_front #(
  parameter int NUM_VIRT = rcsfm_pkg::NUM_VIRT_DEF
) (
  rcsfm_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             q_push,
  output rcsfm_pkg::cmd_t  q_cmd
);
  import rcsfm_pkg::*;

  // Take a beat whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classify the request; out-of-range register numbers on map requests become errors
  always_comb begin
    q_cmd.vr = in_ch.virt_reg;
    case (in_ch.opcode)
      OP_MAP_RD: q_cmd.kind = (5'(in_ch.virt_reg) >= 5'(NUM_VIRT)) ? CMD_ERROR : CMD_READ;
      OP_MAP_WR: q_cmd.kind = (5'(in_ch.virt_reg) >= 5'(NUM_VIRT)) ? CMD_ERROR : CMD_WRITE;
      OP_FLUSH:  q_cmd.kind = CMD_FLUSH;
      OP_CLEAR:  q_cmd.kind = CMD_CLEAR;
      default:   q_cmd.kind = CMD_ERROR;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rcsfm_queue.sv */
`default_nettype none

module rcsfm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rcsfm_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output rcsfm_pkg::cmd_t pop_cmd,
  output logic            nonempty
);
  import rcsfm_pkg::*;

`include "register_cache_spill_fill_map_assert.svh"

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  cmd_t          buf_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(Q_DEPTH));
  assign nonempty = (count_r != '0);
  assign pop_cmd  = buf_r[rd_ptr_r];

  // Pointer and fill-level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

  `RCSFM_ASSERT(q_pop_nonempty, clk, rst_n, pop, count_r != '0)
  `RCSFM_ASSERT(q_push_room, clk, rst_n, push, count_r != CW'(Q_DEPTH))
  `RCSFM_ASSERT(q_count_bound, clk, rst_n, 1'b1, count_r <= CW'(Q_DEPTH))

endmodule

`default_nettype wire

/* rtl/rcsfm_back.sv */
`default_nettype none

module rcsfm_back #(
  parameter int NUM_VIRT = rcsfm_pkg::NUM_VIRT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  rcsfm_pkg::cmd_t q_cmd,
  output logic            q_pop,
  rcsfm_out_if.source     out_ch
);
  import rcsfm_pkg::*;

`include "register_cache_spill_fill_map_assert.svh"

  localparam int IW = $clog2(NUM_VIRT);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_LOOK  = 7'b0000010,
    B_EVICT = 7'b0000100,
    B_FILL  = 7'b0001000,
    B_ANS   = 7'b0010000,
    B_FLUSH = 7'b0100000,
    B_DONE  = 7'b1000000
  } bstate_t;

  bstate_t       state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [IW-1:0] vic_idx_r, vic_idx_nxt;
  logic          vic_found_r, vic_found_nxt;
  logic [3:0]    next_pool_r, next_pool_nxt;

  // Map table: valid/dirty flops per entry, physical register per entry
  logic [NUM_VIRT-1:0] valid_r;
  logic [NUM_VIRT-1:0] dirty_r;
  logic [3:0]          phys_r [NUM_VIRT];

  // Output register
  logic        out_valid_r, out_valid_nxt;
  res_kind_t   out_kind_r;
  logic [3:0]  out_phys_r;
  logic [3:0]  out_vreg_r;
  logic [31:0] out_word_r;
  logic        out_last_r;

  logic          emit_ok;
  logic          emit;
  res_kind_t     emit_kind;
  logic [3:0]    emit_phys;
  logic [3:0]    emit_vreg;
  logic [31:0]   emit_word;
  logic          emit_last;

  logic          tbl_clr_all;
  logic          tbl_clr_one;
  logic [IW-1:0] tbl_clr_idx;
  logic          tbl_set_dirty;
  logic          tbl_install;
  logic          tbl_inst_dirty;

  logic [IW-1:0]       vr_idx;
  logic [IW-1:0]       rd_idx;
  logic                ent_valid;
  logic                ent_dirty;
  logic [3:0]          ent_phys;
  logic [NUM_VIRT-1:0] vic_match;
  logic [IW:0]         vic_sel;
  logic [IW:0]         fl_sel;
  logic [4:0]          pool_inc;

  // Lowest set bit: {found, index}
  function automatic logic [IW:0] first_set(input logic [NUM_VIRT-1:0] v);
    logic [IW:0] r;
    r = '0;
    for (int i = NUM_VIRT - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, IW'(i)};
    end
    return r;
  endfunction

  assign vr_idx  = cmd_r.vr[IW-1:0];
  assign emit_ok = !out_valid_r || out_ch.ready;

  // Victim: valid entry holding the next pool register
  always_comb begin
    for (int i = 0; i < NUM_VIRT; i++) begin
      vic_match[i] = valid_r[i] && (phys_r[i] == next_pool_r);
    end
  end
  assign vic_sel = first_set(vic_match);

  // Flush walks dirty entries lowest first
  assign fl_sel = first_set(valid_r & dirty_r);

  // Single table read port
  always_comb begin
    case (state_r)
      B_LOOK:  rd_idx = vr_idx;
      B_EVICT: rd_idx = vic_idx_r;
      default: rd_idx = fl_sel[IW-1:0];
    endcase
  end
  assign ent_valid = valid_r[rd_idx];
  assign ent_dirty = dirty_r[rd_idx];
  assign ent_phys  = phys_r[rd_idx];

  // Round-robin pool advance
  assign pool_inc = {1'b0, next_pool_r} + 5'd1;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    vic_idx_nxt    = vic_idx_r;
    vic_found_nxt  = vic_found_r;
    next_pool_nxt  = next_pool_r;
    q_pop          = 1'b0;
    emit           = 1'b0;
    emit_kind      = RES_ANSWER;
    emit_phys      = '0;
    emit_vreg      = '0;
    emit_word      = '0;
    emit_last      = 1'b0;
    tbl_clr_all    = 1'b0;
    tbl_clr_one    = 1'b0;
    tbl_clr_idx    = rd_idx;
    tbl_set_dirty  = 1'b0;
    tbl_install    = 1'b0;
    tbl_inst_dirty = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_nonempty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            CMD_ERROR: state_nxt = B_DONE;
            CMD_FLUSH,
            CMD_CLEAR: state_nxt = B_FLUSH;
            default:   state_nxt = B_LOOK;
          endcase
        end
      end
      B_LOOK: begin
        if (ent_valid) begin
          // hit: answer as soon as the result register can take it
          if (emit_ok) begin
            emit          = 1'b1;
            emit_kind     = RES_ANSWER;
            emit_phys     = ent_phys;
            emit_vreg     = cmd_r.vr;
            emit_last     = 1'b1;
            tbl_set_dirty = (cmd_r.kind == CMD_WRITE);
            state_nxt     = B_IDLE;
          end
        end else begin
          vic_idx_nxt   = vic_sel[IW-1:0];
          vic_found_nxt = vic_sel[IW];
          state_nxt     = B_EVICT;
        end
      end
      B_EVICT: begin
        if (vic_found_r && ent_dirty) begin
          if (emit_ok) begin
            emit        = 1'b1;
            emit_kind   = RES_SPILL;
            emit_phys   = next_pool_r;
            emit_vreg   = 4'(vic_idx_r);
            emit_word   = make_word(STORE_BASE, next_pool_r, 4'(vic_idx_r));
            tbl_clr_one = 1'b1;
            state_nxt   = (cmd_r.kind == CMD_WRITE) ? B_ANS : B_FILL;
          end
        end else begin
          tbl_clr_one = vic_found_r;
          state_nxt   = (cmd_r.kind == CMD_WRITE) ? B_ANS : B_FILL;
        end
      end
      B_FILL: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_kind = RES_FILL;
          emit_phys = next_pool_r;
          emit_vreg = cmd_r.vr;
          emit_word = make_word(LOAD_BASE, next_pool_r, cmd_r.vr);
          state_nxt = B_ANS;
        end
      end
      B_ANS: begin
        if (emit_ok) begin
          emit           = 1'b1;
          emit_kind      = RES_ANSWER;
          emit_phys      = next_pool_r;
          emit_vreg      = cmd_r.vr;
          emit_last      = 1'b1;
          tbl_install    = 1'b1;
          tbl_inst_dirty = (cmd_r.kind == CMD_WRITE);
          next_pool_nxt  = (pool_inc >= 5'(POOL_END)) ? 4'(POOL_FIRST) : pool_inc[3:0];
          state_nxt      = B_IDLE;
        end
      end
      B_FLUSH: begin
        if ((cmd_r.kind == CMD_FLUSH) && fl_sel[IW]) begin
          if (emit_ok) begin
            emit        = 1'b1;
            emit_kind   = RES_SPILL;
            emit_phys   = ent_phys;
            emit_vreg   = 4'(fl_sel[IW-1:0]);
            emit_word   = make_word(STORE_BASE, ent_phys, 4'(fl_sel[IW-1:0]));
            tbl_clr_one = 1'b1;
          end
        end else begin
          tbl_clr_all = 1'b1;
          state_nxt   = B_DONE;
        end
      end
      B_DONE: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_kind = (cmd_r.kind == CMD_ERROR) ? RES_ERROR : RES_DONE;
          emit_last = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      next_pool_r <= 4'(POOL_FIRST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_pool_r <= next_pool_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and victim latches
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_found_r <= vic_found_nxt;
  end

  // Table flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else if (tbl_clr_all) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (tbl_clr_one) begin
        valid_r[tbl_clr_idx] <= 1'b0;
        dirty_r[tbl_clr_idx] <= 1'b0;
      end
      if (tbl_set_dirty) begin
        dirty_r[vr_idx] <= 1'b1;
      end
      if (tbl_install) begin
        valid_r[vr_idx] <= 1'b1;
        dirty_r[vr_idx] <= tbl_inst_dirty;
      end
    end
  end

  // Table physical registers
  always_ff @(posedge clk) begin
    if (tbl_install) begin
      phys_r[vr_idx] <= next_pool_r;
    end
  end

  // Result register: loads when empty or being drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= emit_kind;
      out_phys_r <= emit_phys;
      out_vreg_r <= emit_vreg;
      out_word_r <= emit_word;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.phys_reg  = out_phys_r;
  assign out_ch.vreg_out  = out_vreg_r;
  assign out_ch.code_word = out_word_r;
  assign out_ch.last      = out_last_r;

  `RCSFM_ASSERT(pool_in_range, clk, rst_n, 1'b1,
                (next_pool_r >= 4'(POOL_FIRST)) && (5'(next_pool_r) < 5'(POOL_END)))
  `RCSFM_ASSERT(ans_slot_free, clk, rst_n, state_r == B_ANS, !valid_r[vr_idx])
  `RCSFM_ASSERT_NEXT(last_ends_item, clk, rst_n, emit && emit_last, state_r == B_IDLE)

endmodule

`default_nettype wire

/* rtl/register_cache_spill_fill_map.sv */
// Write-back register cache map.
// in_ch carries requests (opcode, virt_reg): map for read, map for write,
// flush dirty entries, or clear the map. out_ch returns result beats
// (kind, phys_reg, vreg_out, code_word, last); last marks the final beat
// of each request. Both channels use valid/ready.
// A request enters a two-deep command queue the cycle it is accepted; the
// back-end sequencer takes one request at a time and owns a single result
// register, so input beats keep being accepted while a result is stalled
// until the queue is full.
// The sequencer takes one table step per cycle. Its steps per request: an
// error goes straight to the final beat; a hit answers from the lookup; a
// miss looks up, evicts the victim (spilling it if dirty), fills on a read
// only, then answers; a flush spills each dirty entry in turn, then clears
// the map and signals done; a clear clears the map with no spill and
// signals done.
// A stalled result holds the sequencer until it is taken.
// Reset (rst_n low, synchronous) invalidates every entry at once, empties
// the queue and the result register, and sets the pool pointer to its
// first register.
`default_nettype none

module register_cache_spill_fill_map #(
  parameter int NUM_VIRT = rcsfm_pkg::NUM_VIRT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rcsfm_in_if.sink    in_ch,
  rcsfm_out_if.source out_ch
);
  import rcsfm_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  cmd_t q_pop_cmd;
  logic q_nonempty;

  rcsfm_front #(.NUM_VIRT(NUM_VIRT)) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  rcsfm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .nonempty (q_nonempty)
  );

  rcsfm_back #(.NUM_VIRT(NUM_VIRT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_cmd      (q_pop_cmd),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcsfm_pkg::*;

  localparam int NV          = NUM_VIRT_DEF;
  localparam int RAND_ITEMS  = 150;
  localparam int HOLD_AT     = 60;    // input beats before the long output stall
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 30;
  localparam int STALL_LIMIT = 3000;  // cycles with no beat on either side

  // One result beat as the block should emit it
  typedef struct packed {
    res_kind_t   kind;
    logic [3:0]  phys;
    logic [3:0]  vreg;
    logic [31:0] word;
    logic        last;
  } res_beat_t;

  // Map table entry
  typedef struct packed {
    logic       valid;
    logic       dirty;
    logic [3:0] phys;
  } slot_t;

  // Directed request; fixed_res marks a single beat typed in by hand
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] vr;
    bit         fixed_res;
    res_kind_t  fixed_kind;
  } req_row_t;

  localparam int NUM_ROWS = 22;
  localparam req_row_t DIR_ROWS [NUM_ROWS] = '{
    '{OP_CLEAR,  4'd0,  1'b1, RES_DONE},    // clear right after reset
    '{OP_FLUSH,  4'd0,  1'b1, RES_DONE},    // flush of an empty map
    '{OP_MAP_RD, 4'd15, 1'b1, RES_ERROR},   // bad virtual register
    '{OP_MAP_WR, 4'd15, 1'b1, RES_ERROR},
    '{OP_MAP_RD, 4'd0,  1'b0, RES_ANSWER},  // read miss, fill
    '{OP_MAP_RD, 4'd0,  1'b0, RES_ANSWER},  // read hit
    '{OP_MAP_WR, 4'd0,  1'b0, RES_ANSWER},  // write hit marks dirty
    '{OP_MAP_WR, 4'd14, 1'b0, RES_ANSWER},  // write miss, no fill
    '{OP_MAP_RD, 4'd1,  1'b0, RES_ANSWER},
    '{OP_MAP_WR, 4'd2,  1'b0, RES_ANSWER},
    '{OP_MAP_RD, 4'd3,  1'b0, RES_ANSWER},
    '{OP_MAP_WR, 4'd4,  1'b0, RES_ANSWER},  // last pool register
    '{OP_MAP_RD, 4'd5,  1'b0, RES_ANSWER},  // pool wraps, dirty victim spilled
    '{OP_MAP_WR, 4'd6,  1'b0, RES_ANSWER},  // dirty victim, write miss
    '{OP_MAP_RD, 4'd1,  1'b0, RES_ANSWER},
    '{OP_FLUSH,  4'd9,  1'b0, RES_ANSWER},  // spills every dirty entry
    '{OP_MAP_RD, 4'd7,  1'b0, RES_ANSWER},  // free victim after flush
    '{OP_MAP_WR, 4'd7,  1'b0, RES_ANSWER},
    '{OP_CLEAR,  4'd5,  1'b1, RES_DONE},    // clear drops dirty entries silently
    '{OP_FLUSH,  4'd15, 1'b1, RES_DONE},
    '{OP_MAP_WR, 4'd10, 1'b0, RES_ANSWER},  // pool pointer survives clear
    '{OP_MAP_RD, 4'd14, 1'b0, RES_ANSWER}
  };

  logic clk;
  logic rst_n;

  rcsfm_in_if  in_ch ();
  rcsfm_out_if out_ch ();

  register_cache_spill_fill_map dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow map state
  slot_t      vmap [NV];
  logic [3:0] pool_ptr;

  res_beat_t step_beats [$];    // beats of the request being predicted
  res_beat_t pending_beats [$]; // beats still owed by the block

  int  errs = 0;
  int  beats_in;
  bit  hold_active;
  bit  hold_done;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] mem_word(logic [31:0] base, logic [3:0] p,
                                           logic [3:0] v);
    return {COND_AL, 28'h0} | base | (32'(p) << 12) | (32'(v) << 2);
  endfunction

  function automatic void add_beat(res_kind_t k, logic [3:0] p, logic [3:0] v,
                                   logic [31:0] w);
    res_beat_t b;
    b.kind = k;
    b.phys = p;
    b.vreg = v;
    b.word = w;
    b.last = 1'b0;
    step_beats.push_back(b);
  endfunction

  // Advance the shadow map by one request and collect the beats it causes
  function automatic void predict_map_beats(logic [1:0] op, logic [3:0] vr);
    int  i;
    int  nxt;
    bit  found;
    step_beats.delete();
    if (op == OP_FLUSH || op == OP_CLEAR) begin
      for (i = 0; i < NV; i++) begin
        if (op == OP_FLUSH && vmap[i].valid && vmap[i].dirty)
          add_beat(RES_SPILL, vmap[i].phys, 4'(i),
                   mem_word(STORE_BASE, vmap[i].phys, 4'(i)));
        vmap[i] = '0;
      end
      add_beat(RES_DONE, 4'd0, 4'd0, 32'd0);
    end else if (int'(vr) >= NV) begin
      add_beat(RES_ERROR, 4'd0, 4'd0, 32'd0);
    end else if (vmap[vr].valid) begin
      if (op == OP_MAP_WR) vmap[vr].dirty = 1'b1;
      add_beat(RES_ANSWER, vmap[vr].phys, vr, 32'd0);
    end else begin
      // evict whoever holds the next pool register
      found = 1'b0;
      for (i = 0; i < NV; i++) begin
        if (!found && vmap[i].valid && vmap[i].phys == pool_ptr) begin
          found = 1'b1;
          if (vmap[i].dirty)
            add_beat(RES_SPILL, pool_ptr, 4'(i), mem_word(STORE_BASE, pool_ptr, 4'(i)));
          vmap[i] = '0;
        end
      end
      vmap[vr].valid = 1'b1;
      vmap[vr].phys  = pool_ptr;
      if (op == OP_MAP_WR) begin
        vmap[vr].dirty = 1'b1;
      end else begin
        vmap[vr].dirty = 1'b0;
        add_beat(RES_FILL, pool_ptr, vr, mem_word(LOAD_BASE, pool_ptr, vr));
      end
      add_beat(RES_ANSWER, pool_ptr, vr, 32'd0);
      nxt = int'(pool_ptr) + 1;
      pool_ptr = (nxt >= POOL_END) ? 4'(POOL_FIRST) : 4'(nxt);
    end
  endfunction

  // Request side
  initial begin : feed
    int         n;
    int         gap;
    int         r;
    bit         steady;
    logic [1:0] op;
    logic [3:0] vr;
    res_beat_t  b;
    for (n = 0; n < NV; n++) vmap[n] = '0;
    pool_ptr        = 4'(POOL_FIRST);
    beats_in        = 0;
    steady          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_MAP_RD;
    in_ch.virt_reg  = 4'd0;
    wait (rst_n);
    @(negedge clk);
    for (n = 0; n < NUM_ROWS + RAND_ITEMS; n++) begin
      if (n < NUM_ROWS) begin
        op = DIR_ROWS[n].op;
        vr = DIR_ROWS[n].vr;
      end else begin
        r = $urandom_range(0, 99);
        op = (r < 44) ? OP_MAP_RD : (r < 88) ? OP_MAP_WR : (r < 95) ? OP_FLUSH : OP_CLEAR;
        vr = ($urandom_range(0, 99) < 6) ? 4'd15 : 4'($urandom_range(0, 14));
      end
      if (n % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = (steady || hold_active || (!hold_done && beats_in >= HOLD_AT)) ? 0 : idle_len();
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid    = 1'b1;
      in_ch.opcode   = op;
      in_ch.virt_reg = vr;
      do @(posedge clk); while (!in_ch.ready);
      predict_map_beats(op, vr);
      if (n < NUM_ROWS && DIR_ROWS[n].fixed_res) begin
        b.kind = DIR_ROWS[n].fixed_kind;
        b.phys = 4'd0;
        b.vreg = 4'd0;
        b.word = 32'd0;
        b.last = 1'b1;
        pending_beats.push_back(b);
      end else begin
        for (r = 0; r < step_beats.size(); r++) begin
          b = step_beats[r];
          b.last = (r == step_beats.size() - 1);
          pending_beats.push_back(b);
        end
      end
      beats_in++;
      @(negedge clk);
    end
    in_ch.valid = 1'b0;

    // let the block drain, then watch for stray beats
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errs == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Result side: ready runs and stalls, plus one long hold-off
  initial begin : drain
    int run;
    int gap;
    hold_active  = 1'b0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_done    = 1'b1;
        hold_active  = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active  = 1'b0;
      end
      run = $urandom_range(1, 20);
      out_ch.ready = 1'b1;
      repeat (run) @(negedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : check
    res_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d phys %0d vreg %0d word %h",
               out_ch.kind, out_ch.phys_reg, out_ch.vreg_out, out_ch.code_word);
        errs++;
      end else begin
        want = pending_beats.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          errs++;
        end
        if (out_ch.phys_reg !== want.phys) begin
          $error("phys_reg: expected %0d, got %0d", want.phys, out_ch.phys_reg);
          errs++;
        end
        if (out_ch.vreg_out !== want.vreg) begin
          $error("vreg_out: expected %0d, got %0d", want.vreg, out_ch.vreg_out);
          errs++;
        end
        if (out_ch.code_word !== want.word) begin
          $error("code_word: expected %h, got %h", want.word, out_ch.code_word);
          errs++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          errs++;
        end
      end
    end
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/rcsfm_pkg.sv
rtl/rcsfm_if.sv
rtl/rcsfm_front.sv
rtl/rcsfm_queue.sv
rtl/rcsfm_back.sv
rtl/register_cache_spill_fill_map.sv
bench/tb.sv
